// ===== sv/dq_pkg.sv =====
// shared types and constants for the double-ended queue
package dq_pkg;

  localparam int unsigned WordWidth = 32;
  localparam int unsigned KindWidth = 3;
  localparam int unsigned StatusWidth = 2;
  localparam int unsigned OpQueueDepth = 2;

  typedef enum logic [KindWidth-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_DUMP_FWD   = 3'd4,
    OP_DUMP_BWD   = 3'd5
  } dq_op_e;

  typedef enum logic [StatusWidth-1:0] {
    STAT_DATA  = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } dq_status_e;

  typedef struct packed {
    dq_op_e                       op;
    logic signed [WordWidth-1:0]  value;
  } dq_cmd_t;

endpackage

// ===== sv/dq_front.sv =====
// front end: accepts transactions, drops unused kinds, queues operations
module dq_front (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic [dq_pkg::KindWidth-1:0]           in_kind_i,
  input  logic signed [dq_pkg::WordWidth-1:0]    in_value_i,
  output logic                                   cmd_valid_o,
  output dq_pkg::dq_cmd_t                        cmd_o,
  input  logic                                   cmd_pop_i
);

  localparam int unsigned CntW = $clog2(dq_pkg::OpQueueDepth + 1);
  localparam int unsigned PtrW = $clog2(dq_pkg::OpQueueDepth);
  localparam int unsigned KindW = dq_pkg::KindWidth;

  dq_pkg::dq_cmd_t ent_q [dq_pkg::OpQueueDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            accept, is_op, push, pop;
  dq_pkg::dq_cmd_t cmd_new;

  assign in_stall_o = (cnt_q == CntW'(dq_pkg::OpQueueDepth));
  assign accept     = in_valid_i && !in_stall_o;
  // kinds past the last dump code do nothing
  assign is_op      = (in_kind_i <= KindW'(dq_pkg::OP_DUMP_BWD));
  assign push       = accept && is_op;
  assign pop        = cmd_pop_i && cmd_valid_o;

  assign cmd_new.op    = dq_pkg::dq_op_e'(in_kind_i);
  assign cmd_new.value = in_value_i;

  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o       = ent_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(dq_pkg::OpQueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(dq_pkg::OpQueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      ent_q[wr_ptr_q] <= cmd_new;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(dq_pkg::OpQueueDepth))
    else $error("op queue count out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && !is_op && !pop) |=> (cnt_q == $past(cnt_q)))
    else $error("unused kind entered the op queue");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0) |-> (wr_ptr_q == rd_ptr_q))
    else $error("op queue pointers disagree when empty");

endmodule

// ===== sv/dq_back.sv =====
// back end: ring store, pointer updates and result generation
module dq_back #(
  parameter int unsigned DEPTH = 32
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cmd_valid_i,
  input  dq_pkg::dq_cmd_t                      cmd_i,
  output logic                                 cmd_pop_o,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [dq_pkg::WordWidth-1:0]  out_word_o,
  output logic [dq_pkg::StatusWidth-1:0]       out_status_o,
  output logic                                 out_last_o
);

  localparam int unsigned IdxW = $clog2(DEPTH);
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam int unsigned SumW = IdxW + 1;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_DUMP = 1'b1;

  logic signed [dq_pkg::WordWidth-1:0] mem [DEPTH];

  logic                 state_q, state_d;
  logic [IdxW-1:0]      front_q, front_d;
  logic [CntW-1:0]      count_q, count_d;
  logic [IdxW-1:0]      ptr_q, ptr_d;
  logic [CntW-1:0]      remain_q, remain_d;
  logic                 fwd_q, fwd_d;

  logic                 ovalid_q;
  dq_pkg::dq_status_e   ostatus_q;
  logic                 olast_q;
  logic signed [dq_pkg::WordWidth-1:0] rd_q;

  logic                 adv, full, empty;
  logic                 emit, emit_last, rd_en, wr_en;
  dq_pkg::dq_status_e   emit_status;
  logic [IdxW-1:0]      wr_addr;
  logic [IdxW-1:0]      front_inc, front_dec, back_pos, tail_pos, ptr_inc, ptr_dec;
  logic [SumW-1:0]      back_sum, tail_sum;

  assign adv   = !ovalid_q || !out_stall_i;
  assign full  = (count_q == CntW'(DEPTH));
  assign empty = (count_q == '0);

  // ring arithmetic, each sum stays below twice the depth
  assign front_inc = (front_q == IdxW'(DEPTH - 1)) ? '0 : front_q + 1'b1;
  assign front_dec = (front_q == '0) ? IdxW'(DEPTH - 1) : front_q - 1'b1;
  assign ptr_inc   = (ptr_q == IdxW'(DEPTH - 1)) ? '0 : ptr_q + 1'b1;
  assign ptr_dec   = (ptr_q == '0) ? IdxW'(DEPTH - 1) : ptr_q - 1'b1;
  assign tail_sum  = {1'b0, front_q} + SumW'(count_q);
  assign back_sum  = tail_sum - 1'b1;
  assign tail_pos  = (tail_sum >= SumW'(DEPTH)) ? IdxW'(tail_sum - SumW'(DEPTH))
                                                : IdxW'(tail_sum);
  assign back_pos  = (back_sum >= SumW'(DEPTH)) ? IdxW'(back_sum - SumW'(DEPTH))
                                                : IdxW'(back_sum);

  always_comb begin
    state_d     = state_q;
    front_d     = front_q;
    count_d     = count_q;
    ptr_d       = ptr_q;
    remain_d    = remain_q;
    fwd_d       = fwd_q;
    cmd_pop_o   = 1'b0;
    emit        = 1'b0;
    emit_status = dq_pkg::STAT_DATA;
    emit_last   = 1'b1;
    rd_en       = 1'b0;
    wr_en       = 1'b0;
    wr_addr     = tail_pos;
    unique case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          unique case (cmd_i.op)
            dq_pkg::OP_PUSH_FRONT, dq_pkg::OP_PUSH_BACK: begin
              if (full) begin
                if (adv) begin
                  emit        = 1'b1;
                  emit_status = dq_pkg::STAT_FULL;
                  cmd_pop_o   = 1'b1;
                end
              end else begin
                wr_en     = 1'b1;
                count_d   = count_q + 1'b1;
                cmd_pop_o = 1'b1;
                if (cmd_i.op == dq_pkg::OP_PUSH_FRONT) begin
                  wr_addr = front_dec;
                  front_d = front_dec;
                end
              end
            end
            dq_pkg::OP_POP_FRONT: begin
              cmd_pop_o = 1'b1;
              if (!empty) begin
                front_d = front_inc;
                count_d = count_q - 1'b1;
              end
            end
            dq_pkg::OP_POP_BACK: begin
              cmd_pop_o = 1'b1;
              if (!empty) begin
                count_d = count_q - 1'b1;
              end
            end
            dq_pkg::OP_DUMP_FWD, dq_pkg::OP_DUMP_BWD: begin
              if (empty) begin
                if (adv) begin
                  emit        = 1'b1;
                  emit_status = dq_pkg::STAT_EMPTY;
                  cmd_pop_o   = 1'b1;
                end
              end else begin
                state_d  = S_DUMP;
                remain_d = count_q;
                fwd_d    = (cmd_i.op == dq_pkg::OP_DUMP_FWD);
                ptr_d    = (cmd_i.op == dq_pkg::OP_DUMP_FWD) ? front_q : back_pos;
              end
            end
            default: begin
              cmd_pop_o = 1'b1;
            end
          endcase
        end
      end
      S_DUMP: begin
        if (adv) begin
          emit      = 1'b1;
          rd_en     = 1'b1;
          emit_last = (remain_q == CntW'(1));
          remain_d  = remain_q - 1'b1;
          ptr_d     = fwd_q ? ptr_inc : ptr_dec;
          if (remain_q == CntW'(1)) begin
            state_d   = S_IDLE;
            cmd_pop_o = 1'b1;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      front_q  <= '0;
      count_q  <= '0;
      ptr_q    <= '0;
      remain_q <= '0;
      fwd_q    <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      front_q  <= front_d;
      count_q  <= count_d;
      ptr_q    <= ptr_d;
      remain_q <= remain_d;
      fwd_q    <= fwd_d;
      if (adv) begin
        ovalid_q <= emit;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && emit) begin
      ostatus_q <= emit_status;
      olast_q   <= emit_last;
    end
  end

  // ring store, read data doubles as the output word register
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= cmd_i.value;
    end
    if (rd_en) begin
      rd_q <= mem[ptr_q];
    end
  end

  assign out_valid_o  = ovalid_q;
  assign out_status_o = ostatus_q;
  assign out_last_o   = olast_q;
  assign out_word_o   = (ostatus_q == dq_pkg::STAT_DATA) ? rd_q : '0;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q <= CntW'(DEPTH)) && (front_q <= IdxW'(DEPTH - 1)))
    else $error("queue pointers out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DUMP) |-> (remain_q != '0) && (remain_q <= count_q))
    else $error("dump counter inconsistent with occupancy");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(wr_en && rd_en))
    else $error("store written during a dump");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DUMP) |=> (count_q == $past(count_q)) && (front_q == $past(front_q)))
    else $error("queue state changed during a dump");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DUMP && adv && remain_q == CntW'(1)) |=> (state_q == S_IDLE && olast_q))
    else $error("dump did not end on its last entry");

endmodule

// ===== sv/double_ended_queue.sv =====
// top level of the bounded double-ended queue of signed words
//
// input channel: in_valid_i / in_stall_o with in_kind_i and in_value_i; one
// transaction is one operation (push front, push back, pop front, pop back,
// dump forward, dump backward). kinds 6 and 7 are taken and discarded.
// output channel: out_valid_o / out_stall_i with out_word_o, out_status_o and
// out_last_o. pushes and pops give no result; a push onto a full queue gives
// one overflow result; a dump gives every stored entry in order with last on
// the final one, or a single empty-status result for an empty queue.
// timing: a transaction sits in a registered two-entry op queue until the
// back end, when idle, takes it; an overflow or empty-dump result is held in
// the output register, and the first entry of a dump comes after the back end
// first loads the dump pointer. pushes and pops retire one per cycle while no
// dump runs and no overflow result is held up; a dump reads one entry per
// cycle unless the receiver stalls, via the ring store's single read port.
// stalls: when the receiver stalls, the output register holds and results
// wait; the op queue keeps taking transactions until both slots fill.
// reset: rst_ni is asynchronous; the queue comes up empty with its front
// pointer at zero and both channels idle. no clearing pass is needed.
module double_ended_queue #(
  parameter int unsigned DEPTH = 32
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [dq_pkg::KindWidth-1:0]         in_kind_i,
  input  logic signed [dq_pkg::WordWidth-1:0]  in_value_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [dq_pkg::WordWidth-1:0]  out_word_o,
  output logic [dq_pkg::StatusWidth-1:0]       out_status_o,
  output logic                                 out_last_o
);

  // decoded operation handed from the front end to the back end
  logic            cmd_valid;
  logic            cmd_pop;
  dq_pkg::dq_cmd_t cmd;

  // classification and buffering of incoming transactions
  dq_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_kind_i   (in_kind_i),
    .in_value_i  (in_value_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  // ring store, pointers and result stage
  dq_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_valid_i  (cmd_valid),
    .cmd_i        (cmd),
    .cmd_pop_o    (cmd_pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_word_o   (out_word_o),
    .out_status_o (out_status_o),
    .out_last_o   (out_last_o)
  );

endmodule
